[design/load_cell_adc_serial_reader_unit_assert.svh]
// Assertion macros used by the top-level design file.
// LCR_ASSERT_IMP checks an overlapping implication, LCR_ASSERT_NXT a non-overlapping
// one. Both expect signals named clk and arst_n in the using scope.
`ifndef LOAD_CELL_ADC_SERIAL_READER_UNIT_ASSERT_SVH
`define LOAD_CELL_ADC_SERIAL_READER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define LCR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define LCR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LCR_ASSERT_IMP(lbl, ante, cons, msg)
`define LCR_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[design/lcr_pkg.sv]
package lcr_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int MAX_AVERAGE = 64;
	localparam int SUM_W       = SAMPLE_BITS + $clog2(MAX_AVERAGE);
	localparam int CNT_W       = $clog2(MAX_AVERAGE + 1);
	localparam int BIT_W       = $clog2(SAMPLE_BITS + 1);
	localparam int ITER_W      = $clog2(SUM_W);
	localparam int ADDR_W      = 4;

	// Register indexes on the configuration port.
	typedef enum logic [1:0] {
		REG_GAIN  = 2'd0,
		REG_AVG   = 2'd1,
		REG_TARE  = 2'd2,
		REG_PDOWN = 2'd3
	} reg_idx_t;

	// Gain codes; each selects how many pulses follow the data bits.
	localparam logic [1:0] GAIN_64 = 2'd1;
	localparam logic [1:0] GAIN_32 = 2'd2;

	typedef enum logic [2:0] {
		PH_IDLE       = 3'd0,
		PH_WAIT       = 3'd1,
		PH_BIT_HIGH   = 3'd2,
		PH_BIT_LOW    = 3'd3,
		PH_PULSE_HIGH = 3'd4,
		PH_PULSE_LOW  = 3'd5
	} phase_t;

	typedef enum logic {
		TOP_READY = 1'b0,
		TOP_DIV   = 1'b1
	} top_state_t;

	typedef struct packed {
		logic             clock_level;
		logic             busy;
		logic             finish;
		logic [SUM_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} seq_step_t;

	typedef struct packed {
		logic gain_lo;
		logic gain_hi;
	} gain_bits_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef struct packed {
		logic [1:0] gain_select;
		logic [6:0] average_count;
		logic       power_down;
	} seq_cfg_t;

endpackage

[design/lcr_if.sv]
interface lcr_in_if;
	import lcr_pkg::*;
	logic valid;
	logic ready;
	logic data_level;
	logic start_req;

	modport source (output valid, output data_level, output start_req, input ready);
	modport sink (input valid, input data_level, input start_req, output ready);
endinterface

interface lcr_out_if;
	import lcr_pkg::*;
	logic                        valid;
	logic                        ready;
	logic                        clock_level;
	logic                        busy_res;
	logic                        result_valid;
	logic [SAMPLE_BITS-1:0]      average_value;
	logic signed [SAMPLE_BITS:0] net_value;

	modport source (output valid, output clock_level, output busy_res, output result_valid,
		output average_value, output net_value, input ready);
	modport sink (input valid, input clock_level, input busy_res, input result_valid,
		input average_value, input net_value, output ready);
endinterface

[design/lcr_seq.sv]
module lcr_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step_en,
	input  logic               data_level,
	input  logic               start_req,
	input  lcr_pkg::seq_cfg_t  cfg,
	output lcr_pkg::seq_step_t step
);
	import lcr_pkg::*;

	phase_t                 phase_q, phase_d;
	logic [BIT_W-1:0]       bit_idx_q, bit_idx_d;
	logic [SAMPLE_BITS-1:0] shift_q, shift_d;
	logic [1:0]             pulses_q, pulses_d;
	logic [SUM_W-1:0]       sum_q, sum_d;
	logic [CNT_W-1:0]       cnt_q, cnt_d;
	logic                   clk_q, clk_d;

	logic [SAMPLE_BITS-1:0] reading;
	logic [SUM_W-1:0]       sum_add;
	logic [CNT_W-1:0]       cnt_add;
	logic [CNT_W-1:0]       wanted;
	logic [BIT_W-1:0]       bit_inc;
	logic [1:0]             pulse_cnt;
	logic [1:0]             pulses_dec;
	logic                   finish;

	always_comb begin
		reading = {~shift_q[SAMPLE_BITS-1], shift_q[SAMPLE_BITS-2:0]};
		sum_add = sum_q + SUM_W'(reading);
		cnt_add = cnt_q + CNT_W'(1);
		bit_inc = bit_idx_q + BIT_W'(1);
		pulses_dec = (pulses_q != 2'd0) ? pulses_q - 2'd1 : 2'd0;
		if (cfg.average_count == 7'd0) begin
			wanted = CNT_W'(1);
		end else if (int'(cfg.average_count) > MAX_AVERAGE) begin
			wanted = CNT_W'(MAX_AVERAGE);
		end else begin
			wanted = CNT_W'(cfg.average_count);
		end
		if (cfg.gain_select == GAIN_64) begin
			pulse_cnt = 2'd3;
		end else if (cfg.gain_select == GAIN_32) begin
			pulse_cnt = 2'd2;
		end else begin
			pulse_cnt = 2'd1;
		end

		phase_d   = phase_q;
		bit_idx_d = bit_idx_q;
		shift_d   = shift_q;
		pulses_d  = pulses_q;
		sum_d     = sum_q;
		cnt_d     = cnt_q;
		clk_d     = clk_q;
		finish    = 1'b0;

		if (cfg.power_down) begin
			phase_d = PH_IDLE;
			sum_d   = '0;
			cnt_d   = '0;
			clk_d   = 1'b1;
		end else begin
			case (phase_q)
				PH_WAIT: begin
					if (!data_level) begin
						bit_idx_d = '0;
						shift_d   = '0;
						clk_d     = 1'b1;
						phase_d   = PH_BIT_LOW;
					end else begin
						clk_d = 1'b0;
					end
				end
				PH_BIT_HIGH: begin
					clk_d   = 1'b1;
					phase_d = PH_BIT_LOW;
				end
				PH_BIT_LOW: begin
					// One data bit enters the shift register per clock pulse.
					shift_d   = {shift_q[SAMPLE_BITS-2:0], data_level};
					bit_idx_d = bit_inc;
					clk_d     = 1'b0;
					if (bit_inc >= BIT_W'(SAMPLE_BITS)) begin
						pulses_d = pulse_cnt;
						phase_d  = PH_PULSE_HIGH;
					end else begin
						phase_d = PH_BIT_HIGH;
					end
				end
				PH_PULSE_HIGH: begin
					clk_d   = 1'b1;
					phase_d = PH_PULSE_LOW;
				end
				PH_PULSE_LOW: begin
					clk_d    = 1'b0;
					pulses_d = pulses_dec;
					if (pulses_dec != 2'd0) begin
						phase_d = PH_PULSE_HIGH;
					end else if (cnt_add >= wanted) begin
						finish  = 1'b1;
						sum_d   = '0;
						cnt_d   = '0;
						phase_d = PH_IDLE;
					end else begin
						sum_d   = sum_add;
						cnt_d   = cnt_add;
						phase_d = PH_WAIT;
					end
				end
				default: begin
					phase_d = PH_IDLE;
					clk_d   = 1'b0;
					if (start_req) begin
						sum_d   = '0;
						cnt_d   = '0;
						phase_d = PH_WAIT;
					end
				end
			endcase
		end

		step.clock_level = clk_d;
		step.busy        = (phase_d != PH_IDLE);
		step.finish      = finish;
		step.dividend    = sum_add;
		step.divisor     = cnt_add;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			bit_idx_q <= '0;
			shift_q   <= '0;
			pulses_q  <= '0;
			sum_q     <= '0;
			cnt_q     <= '0;
			clk_q     <= 1'b0;
		end else if (step_en) begin
			phase_q   <= phase_d;
			bit_idx_q <= bit_idx_d;
			shift_q   <= shift_d;
			pulses_q  <= pulses_d;
			sum_q     <= sum_d;
			cnt_q     <= cnt_d;
			clk_q     <= clk_d;
		end
	end

endmodule

[design/lcr_div.sv]
module lcr_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [lcr_pkg::SUM_W-1:0] dividend,
	input  logic [lcr_pkg::CNT_W-1:0] divisor,
	output lcr_pkg::div_stat_t        stat,
	output logic [lcr_pkg::SUM_W-1:0] quotient
);
	import lcr_pkg::*;

	logic [SUM_W-1:0]  work_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dsr_q;
	logic [ITER_W-1:0] iter_q;
	logic              busy_q;
	logic              done_q;
	logic [CNT_W:0]    trial;
	logic              fits;

	// Restoring division, one quotient bit per cycle. The dividend shifts out
	// of the top of work_q while the quotient bits shift in at the bottom.
	always_comb begin
		trial = {rem_q, work_q[SUM_W-1]};
		fits  = (trial >= {1'b0, dsr_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= ITER_W'(SUM_W - 1);
			end else if (busy_q) begin
				iter_q <= iter_q - ITER_W'(1);
				if (iter_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
			dsr_q  <= divisor;
		end else if (busy_q) begin
			work_q <= {work_q[SUM_W-2:0], fits};
			rem_q  <= fits ? CNT_W'(trial - {1'b0, dsr_q}) : trial[CNT_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = work_q;

endmodule

[design/load_cell_adc_serial_reader_unit.sv]
// Channel     Dir  Beat contents
// sample_in   in   data_level, start_req: one timebase tick
// result_out  out  clock_level, busy_res, result_valid, average_value, net_value
// apb         in   gain_select, average_count, tare_offset, power_down at 0x0..0xC
//
// Each accepted tick yields one result beat. A tick that does not complete a
// measurement is answered at its own accept edge, so ticks can arrive every cycle
// while result_out takes every beat. The tick that completes a measurement starts
// the bit-serial divider over the SUM_W (30) bit sum; input is held off till done.
// Reset (arst_n low) returns the sequencer to idle and clears held results.
// A result beat waiting on result_out stalls only the next tick; it is accepted
// in the same cycle that the waiting beat is taken.
`include "load_cell_adc_serial_reader_unit_assert.svh"

module load_cell_adc_serial_reader_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	lcr_in_if.sink                      sample_in,
	lcr_out_if.source                   result_out,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lcr_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import lcr_pkg::*;

	// Configuration registers.
	logic [1:0]             gain_q;
	logic [6:0]             avg_cnt_q;
	logic [SAMPLE_BITS-1:0] tare_q;
	logic                   pdown_q;
	reg_idx_t               reg_idx;
	logic                   cfg_wr;

	seq_cfg_t   seq_cfg;
	seq_step_t  step;
	div_stat_t  div_stat;
	logic [SUM_W-1:0] quotient;

	top_state_t top_state_q, top_state_d;
	logic       in_ready;
	logic       accept;
	logic       div_start;

	// Output register; average and net come straight from the held results.
	logic                        out_valid_q;
	logic                        clk_lvl_q;
	logic                        busy_q;
	logic                        rvalid_q;
	logic [SAMPLE_BITS-1:0]      held_avg_q;
	logic signed [SAMPLE_BITS:0] held_net_q;

	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q    <= 2'd0;
			avg_cnt_q <= 7'd1;
			tare_q    <= '0;
			pdown_q   <= 1'b0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_GAIN:  gain_q    <= pwdata[1:0];
				REG_AVG:   avg_cnt_q <= pwdata[6:0];
				REG_TARE:  tare_q    <= pwdata[SAMPLE_BITS-1:0];
				REG_PDOWN: pdown_q   <= pwdata[0];
				default:   pdown_q   <= pdown_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_GAIN:  prdata = {30'd0, gain_q};
			REG_AVG:   prdata = {25'd0, avg_cnt_q};
			REG_TARE:  prdata = 32'(tare_q);
			REG_PDOWN: prdata = {31'd0, pdown_q};
			default:   prdata = 32'd0;
		endcase
	end

	assign seq_cfg.gain_select   = gain_q;
	assign seq_cfg.average_count = avg_cnt_q;
	assign seq_cfg.power_down    = pdown_q;

	lcr_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (accept),
		.data_level (sample_in.data_level),
		.start_req  (sample_in.start_req),
		.cfg        (seq_cfg),
		.step       (step)
	);

	lcr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (step.dividend),
		.divisor  (step.divisor),
		.stat     (div_stat),
		.quotient (quotient)
	);

	// A tick is taken only when the output slot is empty or being emptied, and
	// never while a division is running.
	always_comb begin
		in_ready    = (top_state_q == TOP_READY) && (!out_valid_q || result_out.ready);
		accept      = sample_in.valid && in_ready;
		div_start   = accept && step.finish;
		top_state_d = top_state_q;
		case (top_state_q)
			TOP_READY: begin
				if (div_start) begin
					top_state_d = TOP_DIV;
				end
			end
			TOP_DIV: begin
				if (div_stat.done) begin
					top_state_d = TOP_READY;
				end
			end
			default: top_state_d = TOP_READY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_state_q <= TOP_READY;
		end else begin
			top_state_q <= top_state_d;
		end
	end

	// The divider finishes only while no tick can be taken, so the first case
	// below never meets the other two in one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			held_avg_q  <= '0;
			held_net_q  <= '0;
		end else begin
			if (div_stat.done) begin
				// The mean always fits the sample width, so the upper quotient
				// bits are zero.
				out_valid_q <= 1'b1;
				held_avg_q  <= quotient[SAMPLE_BITS-1:0];
				held_net_q  <= $signed({1'b0, quotient[SAMPLE_BITS-1:0]} - {1'b0, tare_q});
			end else if (accept && !step.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			clk_lvl_q <= step.clock_level;
			busy_q    <= step.busy;
			rvalid_q  <= step.finish;
		end
	end

	assign sample_in.ready         = in_ready;
	assign result_out.valid        = out_valid_q;
	assign result_out.clock_level  = clk_lvl_q;
	assign result_out.busy_res     = busy_q;
	assign result_out.result_valid = rvalid_q;
	assign result_out.average_value = held_avg_q;
	assign result_out.net_value    = held_net_q;

	`LCR_ASSERT_IMP(a_no_tick_in_div, top_state_q == TOP_DIV, !sample_in.ready, "tick taken during division")
	`LCR_ASSERT_IMP(a_done_in_div, div_stat.done, top_state_q == TOP_DIV, "divider done outside division")
	`LCR_ASSERT_IMP(a_result_not_busy, out_valid_q && rvalid_q, !busy_q, "finished result marked busy")
	`LCR_ASSERT_NXT(a_pdown_clock_high, accept && pdown_q, out_valid_q && clk_lvl_q, "power down clock low")

endmodule

[test/load_cell_adc_serial_reader_unit_tb.sv]
module load_cell_adc_serial_reader_unit_tb;
	import lcr_pkg::*;

	// Gain codes the package leaves unnamed: the default one and the spare one,
	// which the block treats like gain 128 (one extra pulse).
	localparam logic [1:0] GAIN_128    = 2'd0;
	localparam logic [1:0] GAIN_UNUSED = 2'd3;
	localparam logic [31:0] PDOWN_OFF  = 32'd0;
	localparam logic [31:0] PDOWN_ON   = 32'd1;

	// The divider keeps running after the tick that ends a measurement. Registers
	// are only touched once nothing is owed and SETTLE_CYCLES have passed since.
	localparam int SETTLE_CYCLES = SUM_W + 10;
	localparam int DRAIN_LIMIT   = 100000;
	localparam int LONG_STALL    = 250;

	// One result beat as the block presents it.
	typedef struct packed {
		logic                   clock_level;
		logic                   busy;
		logic                   done;
		logic [SAMPLE_BITS-1:0] average;
		logic [SAMPLE_BITS:0]   net;
	} tick_result_t;

	typedef enum logic {
		ROW_TICK = 1'b0,
		ROW_CFG  = 1'b1
	} row_kind_t;

	// A row of the directed script is either one tick or one register write.
	// For ticks whose outcome is plain from the rules, the result is typed in.
	typedef struct packed {
		row_kind_t    kind;
		reg_idx_t     idx;
		logic [31:0]  value;
		logic         data_level;
		logic         start_req;
		logic         typed;
		tick_result_t result;
	} stim_row_t;

	localparam tick_result_t R_IDLE  = '0;
	localparam tick_result_t R_CLKLO = '{1'b0, 1'b1, 1'b0, '0, '0};
	localparam tick_result_t R_CLKHI = '{1'b1, 1'b1, 1'b0, '0, '0};
	localparam tick_result_t R_PDOWN = '{1'b1, 1'b0, 1'b0, '0, '0};

	localparam int SCRIPT_LEN = 19;
	localparam stim_row_t SCRIPT [SCRIPT_LEN] = '{
		// Idle after reset: no start, then a low data pin that must be ignored.
		'{ROW_TICK, REG_GAIN, 32'd0, 1'b1, 1'b0, 1'b1, R_IDLE},
		'{ROW_TICK, REG_GAIN, 32'd0, 1'b0, 1'b0, 1'b1, R_IDLE},
		// Start, then a second start while busy, which changes nothing.
		'{ROW_TICK, REG_GAIN, 32'd0, 1'b1, 1'b1, 1'b1, R_CLKLO},
		'{ROW_TICK, REG_GAIN, 32'd0, 1'b1, 1'b1, 1'b1, R_CLKLO},
		// The tick that sees the pin low already raises the clock for bit one.
		'{ROW_TICK, REG_GAIN, 32'd0, 1'b0, 1'b0, 1'b1, R_CLKHI},
		'{ROW_TICK, REG_GAIN, 32'd0, 1'b1, 1'b0, 1'b1, R_CLKLO},
		'{ROW_TICK, REG_GAIN, 32'd0, 1'b0, 1'b1, 1'b1, R_CLKHI},
		// Power down in the middle of a conversion: clock held high, job dropped,
		// starts ignored. Releasing it leaves the block idle with the clock low.
		'{ROW_CFG,  REG_PDOWN, PDOWN_ON, 1'b0, 1'b0, 1'b0, R_IDLE},
		'{ROW_TICK, REG_GAIN, 32'd0, 1'b0, 1'b1, 1'b1, R_PDOWN},
		'{ROW_TICK, REG_GAIN, 32'd0, 1'b1, 1'b1, 1'b1, R_PDOWN},
		'{ROW_CFG,  REG_PDOWN, PDOWN_OFF, 1'b0, 1'b0, 1'b0, R_IDLE},
		'{ROW_TICK, REG_GAIN, 32'd0, 1'b1, 1'b0, 1'b1, R_IDLE},
		// Spare gain code, a zero average count and the largest tare.
		'{ROW_CFG,  REG_GAIN, {30'd0, GAIN_UNUSED}, 1'b0, 1'b0, 1'b0, R_IDLE},
		'{ROW_CFG,  REG_AVG,  32'd0, 1'b0, 1'b0, 1'b0, R_IDLE},
		'{ROW_CFG,  REG_TARE, 32'h00FF_FFFF, 1'b0, 1'b0, 1'b0, R_IDLE},
		'{ROW_TICK, REG_GAIN, 32'd0, 1'b1, 1'b1, 1'b1, R_CLKLO},
		'{ROW_TICK, REG_GAIN, 32'd0, 1'b0, 1'b1, 1'b1, R_CLKHI},
		'{ROW_TICK, REG_GAIN, 32'd0, 1'b1, 1'b0, 1'b0, R_IDLE},
		'{ROW_TICK, REG_GAIN, 32'd0, 1'b0, 1'b0, 1'b0, R_IDLE}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;

	lcr_in_if  tick_ch ();
	lcr_out_if res_ch ();

	// Typed result that travels with the tick on offer, when there is one.
	logic         typed_on;
	tick_result_t typed_result;

	// Register copies as the block should hold them.
	logic [1:0]             gain_code  = GAIN_128;
	logic [6:0]             avg_target = 7'd1;
	logic [SAMPLE_BITS-1:0] tare_value = '0;
	logic                   pdown_on   = 1'b0;

	// Sequencer copy: the converter handshake, the shift register and the sums.
	phase_t                 seq_ph         = PH_IDLE;
	logic [BIT_W-1:0]       bit_cnt        = '0;
	logic [SAMPLE_BITS-1:0] shift_acc      = '0;
	logic [1:0]             pulses_to_go   = '0;
	logic [SUM_W-1:0]       reading_sum    = '0;
	logic [CNT_W-1:0]       readings_taken = '0;
	logic                   clk_pin        = 1'b0;
	logic [SAMPLE_BITS-1:0] last_avg       = '0;
	logic [SAMPLE_BITS:0]   last_net       = '0;

	tick_result_t predicted_beats [$];
	int beats_taken = 0;
	int done_count  = 0;
	int fail_count  = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	always #4 clk = ~clk;

	load_cell_adc_serial_reader_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_in  (tick_ch),
		.result_out (res_ch),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	// Advances the sequencer copy by one tick and returns the beat it causes.
	task automatic serial_read_step(input logic d, input logic s, output tick_result_t r);
		logic [SAMPLE_BITS-1:0] reading;
		logic [SUM_W-1:0]       mean;
		int                     wanted;
		r = '0;
		if (pdown_on) begin
			seq_ph = PH_IDLE;
			reading_sum = '0;
			readings_taken = '0;
			clk_pin = 1'b1;
		end else begin
			case (seq_ph)
				PH_WAIT: begin
					if (!d) begin
						bit_cnt = '0;
						shift_acc = '0;
						clk_pin = 1'b1;
						seq_ph = PH_BIT_LOW;
					end else begin
						clk_pin = 1'b0;
					end
				end
				PH_BIT_HIGH: begin
					clk_pin = 1'b1;
					seq_ph = PH_BIT_LOW;
				end
				PH_BIT_LOW: begin
					shift_acc = {shift_acc[SAMPLE_BITS-2:0], d};
					bit_cnt = bit_cnt + 1'b1;
					clk_pin = 1'b0;
					if (bit_cnt >= SAMPLE_BITS) begin
						// Gain is latched here, once the data bits are in.
						pulses_to_go = (gain_code == GAIN_64) ? 2'd3 :
							(gain_code == GAIN_32) ? 2'd2 : 2'd1;
						seq_ph = PH_PULSE_HIGH;
					end else begin
						seq_ph = PH_BIT_HIGH;
					end
				end
				PH_PULSE_HIGH: begin
					clk_pin = 1'b1;
					seq_ph = PH_PULSE_LOW;
				end
				PH_PULSE_LOW: begin
					clk_pin = 1'b0;
					if (pulses_to_go != 0)
						pulses_to_go = pulses_to_go - 1'b1;
					if (pulses_to_go != 0) begin
						seq_ph = PH_PULSE_HIGH;
					end else begin
						// Flipping the sign bit turns two's complement into offset binary.
						reading = {~shift_acc[SAMPLE_BITS-1], shift_acc[SAMPLE_BITS-2:0]};
						reading_sum = reading_sum + reading;
						readings_taken = readings_taken + 1'b1;
						wanted = (avg_target == 0) ? 1 :
							(avg_target > MAX_AVERAGE) ? MAX_AVERAGE : int'(avg_target);
						if (int'(readings_taken) >= wanted) begin
							mean = reading_sum / readings_taken;
							last_avg = mean[SAMPLE_BITS-1:0];
							last_net = {1'b0, last_avg} - {1'b0, tare_value};
							r.done = 1'b1;
							reading_sum = '0;
							readings_taken = '0;
							seq_ph = PH_IDLE;
						end else begin
							seq_ph = PH_WAIT;
						end
					end
				end
				default: begin
					seq_ph = PH_IDLE;
					clk_pin = 1'b0;
					if (s) begin
						reading_sum = '0;
						readings_taken = '0;
						seq_ph = PH_WAIT;
					end
				end
			endcase
		end
		r.clock_level = clk_pin;
		r.busy = (seq_ph != PH_IDLE);
		r.average = last_avg;
		r.net = last_net;
	endtask

	function automatic void flag_failure(string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%s", msg);
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want)
			flag_failure($sformatf("beat %0d %s: expected %h, got %h", beats_taken, name,
				want, got));
	endfunction

	// Everything is looked at on the falling edge, where both sides are settled
	// for the rising edge that follows. Ticks are handled before results, though a
	// beat never leaves in the same cycle as its tick, as the block registers it.
	always @(negedge clk) begin
		tick_result_t pred;
		tick_result_t got;
		tick_result_t want;
		if (arst_n === 1'b1) begin
			if (tick_ch.valid === 1'b1 && tick_ch.ready === 1'b1) begin
				serial_read_step(tick_ch.data_level, tick_ch.start_req, pred);
				if (pred.done)
					done_count++;
				predicted_beats.push_back(typed_on ? typed_result : pred);
			end
			if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
				beats_taken++;
				got = {res_ch.clock_level, res_ch.busy_res, res_ch.result_valid,
					res_ch.average_value, res_ch.net_value};
				if (predicted_beats.size() == 0) begin
					flag_failure($sformatf("beat %0d arrived with nothing expected: %h",
						beats_taken, got));
				end else begin
					want = predicted_beats.pop_front();
					check_field("clock_level", 32'(want.clock_level), 32'(got.clock_level));
					check_field("busy_res", 32'(want.busy), 32'(got.busy));
					check_field("result_valid", 32'(want.done), 32'(got.done));
					check_field("average_value", 32'(want.average), 32'(got.average));
					check_field("net_value", 32'(want.net), 32'(got.net));
				end
			end
		end
	end

	// Result side. Besides random back-pressure it goes deaf for a long stretch
	// twice, so the block backs up and has to hold off incoming ticks.
	initial begin : result_sink
		int stall_left;
		int stalled_at;
		stall_left = 0;
		stalled_at = -1;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left == 0 && beats_taken != stalled_at &&
				(beats_taken == 150 || beats_taken == 400)) begin
				stall_left = LONG_STALL;
				stalled_at = beats_taken;
			end
			if (stall_left > 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Offers one tick, with random gaps in front of it, and returns on the edge
	// that takes it.
	task automatic send_tick(input logic d, input logic s, input logic typed,
		input tick_result_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			tick_ch.valid <= 1'b0;
			@(posedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.data_level <= d;
		tick_ch.start_req <= s;
		typed_on <= typed;
		typed_result <= want;
		do @(posedge clk); while (!(tick_ch.valid && tick_ch.ready));
	endtask

	// Stops offering, waits for every owed beat, then lets the divider finish.
	task automatic settle_block();
		tick_ch.valid <= 1'b0;
		while (predicted_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Setup cycle, access cycle, then one quiet cycle so back-to-back writes
	// never assign the bus twice in the same step.
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_GAIN:  gain_code = value[1:0];
			REG_AVG:   avg_target = value[6:0];
			REG_TARE:  tare_value = value[SAMPLE_BITS-1:0];
			default:   pdown_on = value[0];
		endcase
		@(posedge clk);
	endtask

	// One phase of random traffic from a given register setting. Ticks are mostly
	// shaped after where the sequencer copy stands: starts when idle, a few
	// high pin levels before the pin drops, and the bits of a chosen word while
	// shifting. A share of the ticks is pure noise. The phase runs until it has
	// both its tick budget and its count of finished averages.
	task automatic run_phase(input logic [1:0] gain, input logic [6:0] avg,
		input logic [SAMPLE_BITS-1:0] tare, input int min_ticks, input int min_done,
		input int noise_pct, input logic max_words, input logic mid_writes);
		int                     ticks;
		int                     done_start;
		logic                   d;
		logic                   s;
		logic [SAMPLE_BITS-1:0] word;
		settle_block();
		write_reg(REG_PDOWN, PDOWN_OFF);
		write_reg(REG_GAIN, {30'd0, gain});
		write_reg(REG_AVG, {25'd0, avg});
		write_reg(REG_TARE, {8'd0, tare});
		ticks = 0;
		done_start = done_count;
		word = '0;
		while (ticks < min_ticks || done_count - done_start < min_done) begin
			// Now and then a register changes between two ticks, while a
			// measurement may be half done.
			if (mid_writes && $urandom_range(119) == 0) begin
				settle_block();
				case ($urandom_range(3))
					0: write_reg(REG_GAIN, $urandom_range(3));
					1: write_reg(REG_AVG, $urandom_range(2));
					2: write_reg(REG_TARE, $urandom_range(24'hFF_FFFF));
					default: begin
						write_reg(REG_PDOWN, PDOWN_ON);
						repeat ($urandom_range(5, 2))
							send_tick(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, '0);
						settle_block();
						write_reg(REG_PDOWN, PDOWN_OFF);
					end
				endcase
			end
			d = 1'($urandom_range(1));
			s = 1'($urandom_range(1));
			if ($urandom_range(99) >= noise_pct) begin
				case (seq_ph)
					PH_IDLE: s = ($urandom_range(99) < 80);
					PH_WAIT: begin
						d = ($urandom_range(99) >= 40);
						// Largest and smallest readings come up often on purpose.
						if (max_words) begin
							word = 24'h7F_FFFF;
						end else begin
							case ($urandom_range(3))
								0: word = 24'h7F_FFFF;
								1: word = 24'h80_0000;
								default: word = 24'($urandom);
							endcase
						end
					end
					PH_BIT_LOW: d = word[SAMPLE_BITS-1-bit_cnt];
					default: ;
				endcase
			end
			send_tick(d, s, 1'b0, '0);
			ticks++;
		end
	endtask

	initial begin
		int guard;
		arst_n <= 1'b0;
		tick_ch.valid <= 1'b0;
		tick_ch.data_level <= 1'b0;
		tick_ch.start_req <= 1'b0;
		typed_on <= 1'b0;
		typed_result <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Sender mostly busy, receiver mostly stalling.
		send_idle_pct = 9;
		recv_idle_pct = 72;
		for (int i = 0; i < SCRIPT_LEN; i++) begin
			if (SCRIPT[i].kind == ROW_CFG) begin
				settle_block();
				write_reg(SCRIPT[i].idx, SCRIPT[i].value);
			end else begin
				send_tick(SCRIPT[i].data_level, SCRIPT[i].start_req, SCRIPT[i].typed,
					SCRIPT[i].result);
			end
		end

		run_phase(GAIN_128, 7'd1, 24'h00_0000, 0, 2, 8, 1'b0, 1'b1);
		run_phase(GAIN_64, 7'd2, 24'hFF_FFFF, 0, 1, 8, 1'b0, 1'b1);

		// The other way round: sparse ticks, eager receiver.
		send_idle_pct = 72;
		recv_idle_pct = 9;
		run_phase(GAIN_32, 7'd1, 24'($urandom), 0, 2, 8, 1'b0, 1'b1);
		run_phase(GAIN_UNUSED, 7'd0, 24'h80_0000, 0, 1, 8, 1'b0, 1'b1);

		// No idling at all. Full-scale words first, which give the largest
		// reading and sum, then mixed words with a short average.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_phase(2'($urandom_range(3)), 7'd2, 24'($urandom), 0, 1, 0, 1'b1, 1'b0);
		run_phase(2'($urandom_range(3)), 7'($urandom_range(2, 1)), 24'($urandom),
			0, 1, 8, 1'b0, 1'b1);

		tick_ch.valid <= 1'b0;
		guard = 0;
		while (predicted_beats.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (predicted_beats.size() != 0)
			flag_failure($sformatf("%0d expected beats never arrived",
				predicted_beats.size()));
		if (fail_count == 0)
			$display("** load_cell_adc_serial_reader_unit: PASSED **");
		else
			$display("** load_cell_adc_serial_reader_unit: FAILED **");
		$finish;
	end

	// Hang guard, far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("** load_cell_adc_serial_reader_unit: FAILED **");
		$finish;
	end

endmodule

[load_cell_adc_serial_reader_unit.f]
+incdir+design
design/lcr_pkg.sv
design/lcr_if.sv
design/lcr_seq.sv
design/lcr_div.sv
design/load_cell_adc_serial_reader_unit.sv
test/load_cell_adc_serial_reader_unit_tb.sv
